>>> src/valid_skipping_time_search_top_macros.svh
// Assertion macros used by the time search RTL.
`ifndef VALID_SKIPPING_TIME_SEARCH_TOP_MACROS_SVH
`define VALID_SKIPPING_TIME_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Condition implies an expression in the same cycle.
`define VSTS_ASSERT_IMPL(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);
// Condition implies an expression in the following cycle.
`define VSTS_ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);
`else
`define VSTS_ASSERT_IMPL(name, cond, expr, msg)
`define VSTS_ASSERT_NEXT(name, cond, expr, msg)
`endif

`endif

>>> src/vsts_pkg.sv
// Package with the shared types and constants of the time search block.
`timescale 1ns / 1ps
`default_nettype none
package vsts_pkg;

   localparam int DEPTH_DEF = 1024;

   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int WEEK_W = 16;
   localparam int SEC_W  = 40;
   localparam int KEY_W  = 56;
   localparam int COEF_W = 20;
   localparam int PROD_W = WEEK_W + COEF_W;
   localparam int ENTRY_W = KEY_W + 1;

   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // Register index, taken from the word address bit of the APB port.
   localparam logic REG_ENTRY_COUNT = 1'b0;

   // Action codes of an input transaction.
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   localparam logic [KEY_W-1:0] SECONDS_PER_WEEK = 56'd604800;
   localparam logic [KEY_W-1:0] US_PER_SECOND    = 56'd1000000;
   localparam logic [KEY_W-1:0] WEEK_US = SECONDS_PER_WEEK * US_PER_SECOND;

   // The week constant split into two 20-bit halves for the narrow multiplier.
   localparam logic [COEF_W-1:0] WEEK_US_LO = COEF_W'(WEEK_US % (56'd1 << COEF_W));
   localparam logic [COEF_W-1:0] WEEK_US_HI = COEF_W'(WEEK_US >> COEF_W);

   typedef struct packed {
      logic              action;
      logic [IDX_W-1:0]  index;
      logic              valid_req;
      logic [WEEK_W-1:0] week;
      logic [SEC_W-1:0]  second_us;
   } item_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] entry_index;
   } result_type;

endpackage
`default_nettype wire

>>> src/vsts_if.sv
// Valid/ready channel interfaces for the request and response transactions.
`timescale 1ns / 1ps
`default_nettype none
interface vsts_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [vsts_pkg::IDX_W-1:0]  index;
   logic                        valid_req;
   logic [vsts_pkg::WEEK_W-1:0] week;
   logic [vsts_pkg::SEC_W-1:0]  second_us;

   modport source (output valid, action, index, valid_req, week, second_us, input ready);
   modport sink (input valid, action, index, valid_req, week, second_us, output ready);
endinterface

interface vsts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [vsts_pkg::IDX_W-1:0] entry_index;

   modport source (output valid, found, entry_index, input ready);
   modport sink (input valid, found, entry_index, output ready);
endinterface
`default_nettype wire

>>> src/vsts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module vsts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/vsts_key.sv
// Two-step key calculator: week times the microseconds of a week plus the microsecond count.
`timescale 1ns / 1ps
`default_nettype none
module vsts_key (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [vsts_pkg::WEEK_W-1:0] week,
   input  wire logic [vsts_pkg::SEC_W-1:0]  second_us,
   output logic                             done,
   output logic      [vsts_pkg::KEY_W-1:0]  key
);

   logic [vsts_pkg::KEY_W-1:0]  acc_ff, acc_in;
   logic [vsts_pkg::WEEK_W-1:0] week_ff, week_in;
   logic                        run_ff, run_in;
   logic                        phase_ff, phase_in;
   logic                        done_ff, done_in;
   logic [vsts_pkg::COEF_W-1:0] coef;
   logic [vsts_pkg::PROD_W-1:0] prod;
   logic [vsts_pkg::KEY_W-1:0]  addend;

   // One multiplier serves both halves of the constant.
   assign coef   = phase_ff ? vsts_pkg::WEEK_US_HI : vsts_pkg::WEEK_US_LO;
   assign prod   = vsts_pkg::PROD_W'(week_ff) * vsts_pkg::PROD_W'(coef);
   assign addend = phase_ff ? {prod, {vsts_pkg::COEF_W{1'b0}}}
                            : {{(vsts_pkg::KEY_W - vsts_pkg::PROD_W){1'b0}}, prod};

   always_comb begin
      acc_in   = acc_ff;
      week_in  = week_ff;
      run_in   = run_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = {{(vsts_pkg::KEY_W - vsts_pkg::SEC_W){1'b0}}, second_us};
         week_in  = week;
         run_in   = 1'b1;
         phase_in = 1'b0;
      end else if (run_ff) begin
         acc_in   = acc_ff + addend;
         phase_in = 1'b1;
         if (phase_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      acc_ff  <= acc_in;
      week_ff <= week_in;
   end

   assign done = done_ff;
   assign key  = acc_ff;

endmodule
`default_nettype wire

>>> src/vsts_ctrl.sv
// Sequencer that runs table writes and the bounded, invalid-skipping bisection.
`timescale 1ns / 1ps
`default_nettype none
`include "valid_skipping_time_search_top_macros.svh"
module vsts_ctrl #(
   parameter int DEPTH = vsts_pkg::DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         item_valid,
   input  wire vsts_pkg::item_type           item,
   output logic                              item_ready,
   input  wire logic [vsts_pkg::CNT_W-1:0]   entry_count,
   output logic                              key_start,
   input  wire logic                         key_done,
   input  wire logic [vsts_pkg::KEY_W-1:0]   key,
   output logic                              wr_en,
   output logic      [$clog2(DEPTH)-1:0]     wr_addr,
   output logic      [vsts_pkg::ENTRY_W-1:0] wr_data,
   output logic                              rd_en,
   output logic      [$clog2(DEPTH)-1:0]     rd_addr,
   input  wire logic [vsts_pkg::ENTRY_W-1:0] rd_data,
   output logic                              res_valid,
   output vsts_pkg::result_type              res,
   input  wire logic                         res_take
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int NEW = CW + vsts_pkg::CNT_W;
   localparam int WEW = CW + vsts_pkg::IDX_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_KEY    = 4'd1;
   localparam logic [3:0] S_LO_RD  = 4'd2;
   localparam logic [3:0] S_LO_CHK = 4'd3;
   localparam logic [3:0] S_HI_RD  = 4'd4;
   localparam logic [3:0] S_HI_CHK = 4'd5;
   localparam logic [3:0] S_BIS    = 4'd6;
   localparam logic [3:0] S_UP_CHK = 4'd7;
   localparam logic [3:0] S_DN_CHK = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]                 state_ff, state_in;
   logic                       action_ff, action_in;
   logic [AW-1:0]              waddr_ff, waddr_in;
   logic                       wok_ff, wok_in;
   logic                       wvalid_ff, wvalid_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              hi_ff, hi_in;
   logic [CW-1:0]              mid_ff, mid_in;
   logic [CW-1:0]              p_ff, p_in;
   vsts_pkg::result_type       res_ff, res_in;

   logic [CW-1:0]              rd_ptr;
   logic [CW-1:0]              mid_calc;
   logic [NEW-1:0]             count_ext;
   logic [NEW-1:0]             n_ext;
   logic [WEW-1:0]             widx_ext;
   logic [WEW-1:0]             hi_wide;
   logic [WEW-1:0]             p_wide;
   logic                       rd_vld;
   logic [vsts_pkg::KEY_W-1:0] rd_time;
   logic                       key_lt;
   logic                       key_eq;
   logic                       item_accept;
   logic                       probe_now;

   assign item_accept = item_valid && item_ready;
   assign item_ready  = (state_ff == S_IDLE);

   // Entry count above the table depth acts as the depth.
   assign count_ext = {{CW{1'b0}}, entry_count};
   assign n_ext     = (count_ext > NEW'(DEPTH)) ? NEW'(DEPTH) : count_ext;
   assign widx_ext  = {{CW{1'b0}}, item.index};

   assign hi_wide = {{vsts_pkg::IDX_W{1'b0}}, hi_ff};
   assign p_wide  = {{vsts_pkg::IDX_W{1'b0}}, p_ff};

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   // The shared comparator: search key against the entry just read.
   assign rd_vld  = rd_data[vsts_pkg::KEY_W];
   assign rd_time = rd_data[vsts_pkg::KEY_W-1:0];
   assign key_lt  = key < rd_time;
   assign key_eq  = key == rd_time;

   assign probe_now = rd_vld && ((state_ff == S_UP_CHK) || (state_ff == S_DN_CHK));

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      waddr_in  = waddr_ff;
      wok_in    = wok_ff;
      wvalid_in = wvalid_ff;
      n_in      = n_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      p_in      = p_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_ptr    = p_ff;
      wr_en     = 1'b0;
      key_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (item_accept) begin
               action_in = item.action;
               waddr_in  = widx_ext[AW-1:0];
               wok_in    = widx_ext < WEW'(DEPTH);
               wvalid_in = item.valid_req;
               n_in      = n_ext[CW-1:0];
               key_start = 1'b1;
               state_in  = S_KEY;
            end
         end
         S_KEY: begin
            if (key_done) begin
               if (action_ff == vsts_pkg::ACT_WRITE) begin
                  wr_en    = wok_ff;
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  lo_in    = '0;
                  state_in = S_LO_RD;
               end
            end
         end
         S_LO_RD: begin
            if (lo_ff >= n_ff) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_ptr   = lo_ff;
               state_in = S_LO_CHK;
            end
         end
         S_LO_CHK: begin
            if (!rd_vld) begin
               lo_in    = lo_ff + CW'(1);
               state_in = S_LO_RD;
            end else if (key_lt) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               hi_in    = n_ff;
               state_in = S_HI_RD;
            end
         end
         S_HI_RD: begin
            rd_en    = 1'b1;
            rd_ptr   = hi_ff - CW'(1);
            hi_in    = hi_ff - CW'(1);
            state_in = S_HI_CHK;
         end
         S_HI_CHK: begin
            if (!rd_vld) begin
               state_in = S_HI_RD;
            end else if (!key_lt && !key_eq) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_BIS;
            end
         end
         S_BIS: begin
            if ((hi_ff - lo_ff) <= CW'(1)) begin
               res_in.found       = 1'b1;
               res_in.entry_index = hi_wide[vsts_pkg::IDX_W-1:0];
               state_in           = S_DONE;
            end else begin
               mid_in   = mid_calc;
               p_in     = mid_calc;
               rd_en    = 1'b1;
               rd_ptr   = mid_calc;
               state_in = S_UP_CHK;
            end
         end
         S_UP_CHK: begin
            if (!rd_vld) begin
               if ((hi_ff - p_ff) > CW'(1)) begin
                  p_in   = p_ff + CW'(1);
                  rd_en  = 1'b1;
                  rd_ptr = p_ff + CW'(1);
               end else if ((mid_ff - lo_ff) > CW'(1)) begin
                  p_in     = mid_ff - CW'(1);
                  rd_en    = 1'b1;
                  rd_ptr   = mid_ff - CW'(1);
                  state_in = S_DN_CHK;
               end else begin
                  res_in.found       = 1'b1;
                  res_in.entry_index = hi_wide[vsts_pkg::IDX_W-1:0];
                  state_in           = S_DONE;
               end
            end
         end
         S_DN_CHK: begin
            if (!rd_vld) begin
               if ((p_ff - lo_ff) > CW'(1)) begin
                  p_in   = p_ff - CW'(1);
                  rd_en  = 1'b1;
                  rd_ptr = p_ff - CW'(1);
               end else begin
                  res_in.found       = 1'b1;
                  res_in.entry_index = hi_wide[vsts_pkg::IDX_W-1:0];
                  state_in           = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A valid probe narrows the bounds or ends the search on a match.
      if (probe_now) begin
         if (key_eq) begin
            res_in.found       = 1'b1;
            res_in.entry_index = p_wide[vsts_pkg::IDX_W-1:0];
            state_in           = S_DONE;
         end else if (key_lt) begin
            hi_in    = p_ff;
            state_in = S_BIS;
         end else begin
            lo_in    = p_ff;
            state_in = S_BIS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      action_ff <= action_in;
      waddr_ff  <= waddr_in;
      wok_ff    <= wok_in;
      wvalid_ff <= wvalid_in;
      n_ff      <= n_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      p_ff      <= p_in;
      res_ff    <= res_in;
   end

   assign rd_addr   = rd_ptr[AW-1:0];
   assign wr_addr   = waddr_ff;
   assign wr_data   = {wvalid_ff, key};
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   `VSTS_ASSERT_IMPL(a_bounds_ordered, (state_ff == S_BIS), (hi_ff >= lo_ff), "bisection bounds crossed")
   `VSTS_ASSERT_IMPL(a_probe_inside, (state_ff == S_UP_CHK) || (state_ff == S_DN_CHK), (p_ff > lo_ff) && (p_ff < hi_ff), "probe outside the open bounds")
   `VSTS_ASSERT_IMPL(a_lo_in_range, (state_ff == S_LO_CHK), (lo_ff < n_ff), "lower scan read past the entry count")
   `VSTS_ASSERT_IMPL(a_key_done_in_key, key_done, (state_ff == S_KEY), "key finished outside the key wait")
   `VSTS_ASSERT_NEXT(a_take_to_idle, res_take && res_valid, (state_ff == S_IDLE), "sequencer did not return to idle")

endmodule
`default_nettype wire

>>> src/valid_skipping_time_search_top.sv
// Top level of the time search block: APB register, channels, table and sequencer.
`timescale 1ns / 1ps
`default_nettype none
// A write passes through the key unit, the sequencer and the response register.
// A search also scans entries from either end of the table, then runs bisection
// rounds with one table read per probe, through one table read port and the
// single comparator. One transaction is in work at a time, and the next is
// accepted only after the sequencer has handed its result to the response
// register. Reset clears the count register and the control state; the table
// holds no reset value and is defined only where written.
module valid_skipping_time_search_top #(
   parameter int DEPTH = vsts_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   vsts_req_if.sink                           req_chan,
   vsts_rsp_if.source                         rsp_chan,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [vsts_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [vsts_pkg::PDATA_W-1:0]  pwdata,
   output logic      [vsts_pkg::PDATA_W-1:0]  prdata,
   output logic                               pready
);

   localparam int AW = $clog2(DEPTH);

   // The single configuration register. The word address bit selects it;
   // a write to the next word falls outside the register map and is dropped.
   logic [vsts_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       csr_write;
   logic                       csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == vsts_pkg::REG_ENTRY_COUNT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign count_in  = csr_write ? pwdata[vsts_pkg::CNT_W-1:0] : count_ff;
   assign prdata    = csr_hit ? {{(vsts_pkg::PDATA_W - vsts_pkg::CNT_W){1'b0}}, count_ff}
                              : '0;

   // Gather the request channel into one item.
   vsts_pkg::item_type item;
   assign item.action    = req_chan.action;
   assign item.index     = req_chan.index;
   assign item.valid_req = req_chan.valid_req;
   assign item.week      = req_chan.week;
   assign item.second_us = req_chan.second_us;

   logic                              item_ready;
   logic                              key_start;
   logic                              key_done;
   logic [vsts_pkg::KEY_W-1:0]        key;
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic [vsts_pkg::ENTRY_W-1:0]      wr_data;
   logic                              rd_en;
   logic [AW-1:0]                     rd_addr;
   logic [vsts_pkg::ENTRY_W-1:0]      rd_data;
   logic                              res_valid;
   vsts_pkg::result_type              res;
   logic                              res_take;

   assign req_chan.ready = item_ready;

   // The key unit turns week and microseconds into one 56-bit time. It is
   // used for both the time stored by a write and the key of a search.
   vsts_key u_key (
      .clock     (clock),
      .reset     (reset),
      .start     (key_start),
      .week      (item.week),
      .second_us (item.second_us),
      .done      (key_done),
      .key       (key)
   );

   // Each table entry holds its valid mark above the 56-bit time.
   vsts_ram #(
      .WIDTH (vsts_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The sequencer walks the bound scans and the bisection, one table read
   // per probe, through the shared comparator.
   vsts_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_chan.valid),
      .item        (item),
      .item_ready  (item_ready),
      .entry_count (count_ff),
      .key_start   (key_start),
      .key_done    (key_done),
      .key         (key),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   // Response register. A finished result moves in as soon as the register
   // is empty or its current transaction is taken in the same cycle.
   logic                       rsp_valid_ff, rsp_valid_in;
   vsts_pkg::result_type       rsp_res_ff, rsp_res_in;

   assign res_take = res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_res_ff.found;
   assign rsp_chan.entry_index = rsp_res_ff.entry_index;

endmodule
`default_nettype wire

>>> dv/vsts_checker.sv
`timescale 1ns / 1ps
// Checker for the time search block: predicts each response and compares it.
module vsts_checker
   import vsts_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   vsts_req_if                     req_chan,
   vsts_rsp_if                     rsp_chan,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic               pready,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output int                      mismatch_count,
   output int                      results_owed
);

   localparam logic [63:0] US_PER_WEEK = 64'd604800000000;

   logic [KEY_W-1:0] key_table [DEPTH];
   bit               mark_table [DEPTH];
   logic [CNT_W-1:0] span;
   result_type       owed_q [$];
   int               fault_total = 0;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         key_table[i] = '0;
         mark_table[i] = 1'b0;
      end
      span = '0;
      mismatch_count = 0;
      results_owed = 0;
   end

   function automatic logic [KEY_W-1:0] time_key(logic [WEEK_W-1:0] wk, logic [SEC_W-1:0] us);
      logic [63:0] sum;
      sum = 64'(wk) * US_PER_WEEK + 64'(us);
      return sum[KEY_W-1:0];
   endfunction

   // Bounds come from the outermost valid entries; probes slide up, then down,
   // to a valid entry strictly inside the bounds.
   function automatic result_type lookup(logic [KEY_W-1:0] key);
      result_type r;
      int n, lo, hi, mid, p;
      bit ok;
      r = '0;
      n = (span > DEPTH) ? DEPTH : int'(span);
      lo = 0;
      while (lo < n && !mark_table[lo]) lo++;
      if (lo >= n) return r;
      if (key < key_table[lo]) return r;
      hi = n - 1;
      while (!mark_table[hi]) hi--;
      if (key > key_table[hi]) return r;
      r.found = 1'b1;
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         p = mid;
         ok = mark_table[p];
         while (!ok && hi - p > 1) begin
            p++;
            ok = mark_table[p];
         end
         if (!ok) p = mid;
         while (!ok && p - lo > 1) begin
            p--;
            ok = mark_table[p];
         end
         if (!ok) break;
         if (key == key_table[p]) begin
            r.entry_index = IDX_W'(p);
            return r;
         end else if (key > key_table[p]) begin
            lo = p;
         end else begin
            hi = p;
         end
      end
      r.entry_index = IDX_W'(hi);
      return r;
   endfunction

   task automatic flag_fault(input string field, input logic [31:0] want, input logic [31:0] got);
      fault_total++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   always @(posedge clock) begin : watch
      result_type seen, owed;
      if (reset) begin
         span = '0;
         owed_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_COUNT) begin
            span = pwdata[CNT_W-1:0];
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.found = rsp_chan.found;
            seen.entry_index = rsp_chan.entry_index;
            if (owed_q.size() == 0) begin
               flag_fault("unexpected response found", 32'd0, 32'(seen.found));
            end else begin
               owed = owed_q.pop_front();
               if (seen.found !== owed.found)
                  flag_fault("found", 32'(owed.found), 32'(seen.found));
               if (seen.entry_index !== owed.entry_index)
                  flag_fault("entry_index", 32'(owed.entry_index), 32'(seen.entry_index));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.action == ACT_WRITE) begin
               if (int'(req_chan.index) < DEPTH) begin
                  key_table[req_chan.index] = time_key(req_chan.week, req_chan.second_us);
                  mark_table[req_chan.index] = req_chan.valid_req;
               end
               owed_q.push_back('0);
            end else begin
               owed_q.push_back(lookup(time_key(req_chan.week, req_chan.second_us)));
            end
         end
      end
      mismatch_count <= fault_total;
      results_owed <= owed_q.size();
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the time search block: clock, reset, stimulus and verdict.
module tb_top;
   import vsts_pkg::*;

   // Every transaction gets one response. Writes load the time table, searches
   // look up a key; the checker beside the block predicts each response.
   localparam int TABLE_SIZE = DEPTH_DEF;
   localparam int ITEM_GOAL = 1750;
   // The limit leaves ample margin for slow searches and long receiver stalls.
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [63:0] US_PER_WEEK = 64'd604800000000;
   localparam logic [63:0] KEY_MAX = 64'd65536 * US_PER_WEEK - 64'd1;
   localparam logic [CNT_W-1:0] COUNT_TOP = '1;

   typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   int mismatch_count;
   int results_owed;
   int cycle_count = 0;

   // Stimulus bookkeeping: the table contents as planned by the sender, used
   // to pick keys that land on, next to, or outside the stored times.
   logic [63:0]      plan_time [TABLE_SIZE];
   bit               plan_mark [TABLE_SIZE];
   int               filled = 0;
   logic [CNT_W-1:0] count_setting = '0;
   int               burst_left = 0;
   bit               hold_off_pending = 1'b0;
   int               hold_offs = 0;
   int               sent_writes = 0;
   int               sent_searches = 0;
   int               count_writes = 0;

   vsts_req_if req_bus ();
   vsts_rsp_if rsp_bus ();

   initial begin
      req_bus.valid = 1'b0;
      req_bus.action = ACT_WRITE;
      req_bus.index = '0;
      req_bus.valid_req = 1'b0;
      req_bus.week = '0;
      req_bus.second_us = '0;
   end

   valid_skipping_time_search_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   vsts_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_bus),
      .rsp_chan      (rsp_bus),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .mismatch_count(mismatch_count),
      .results_owed  (results_owed)
   );

   always #10 clock = ~clock;

   // The watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [63:0] rand_key();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word % (KEY_MAX + 64'd1);
   endfunction

   // Key choice leans toward stored times and their neighbors so that most
   // searches get through the bounds checks and into the bisection.
   function automatic logic [63:0] pick_key();
      int n, j;
      logic [63:0] t, lo_t, hi_t;
      n = (count_setting > TABLE_SIZE) ? TABLE_SIZE : int'(count_setting);
      if (n == 0) return rand_key();
      j = $urandom_range(0, n - 1);
      lo_t = plan_time[0];
      hi_t = plan_time[n - 1];
      case ($urandom_range(0, 9))
         0, 1, 2, 3: t = plan_time[j];
         4: t = (plan_time[j] < KEY_MAX) ? plan_time[j] + 64'd1 : plan_time[j];
         5: t = (plan_time[j] > 0) ? plan_time[j] - 64'd1 : plan_time[j];
         6, 7: t = (hi_t > lo_t) ? lo_t + ({$urandom, $urandom} % (hi_t - lo_t + 64'd1)) : lo_t;
         8: t = rand_key();
         default: begin
            if ($urandom_range(0, 1) == 0) begin
               t = (lo_t >= 64'd1000) ? lo_t - 64'($urandom_range(1, 1000)) : 64'd0;
            end else begin
               t = hi_t + 64'($urandom_range(1, 1000));
               if (t > KEY_MAX) t = KEY_MAX;
            end
         end
      endcase
      return t;
   endfunction

   // Offers one transaction, starting and ending at a falling edge. The sender
   // works in bursts; an idle gap, which may be empty, separates one burst from the next.
   task automatic drive_item(input logic act, input int idx, input logic mark,
                             input logic [63:0] t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      end
      req_bus.action = act;
      req_bus.index = idx[IDX_W-1:0];
      req_bus.valid_req = mark;
      req_bus.week = WEEK_W'(t / US_PER_WEEK);
      req_bus.second_us = SEC_W'(t % US_PER_WEEK);
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (act == ACT_SEARCH) sent_searches++;
      else sent_writes++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic write_entry(input int idx, input bit mark, input logic [63:0] t);
      plan_time[idx] = t;
      plan_mark[idx] = mark;
      drive_item(ACT_WRITE, idx, mark, t);
   endtask

   task automatic wait_idle();
      while (results_owed != 0) @(negedge clock);
   endtask

   // The count register is only written once every response is back, which
   // also makes the sender pause until the block has drained.
   task automatic set_count(input logic [CNT_W-1:0] value);
      wait_idle();
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {REG_ENTRY_COUNT, 2'b00};
      pwdata = PDATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      count_setting = value;
      count_writes++;
   endtask

   // The receiver changes its stall pattern every so often, and on request
   // holds off for a long stretch so that the block backs up into its input.
   initial begin : response_sink
      sink_mode_type mode;
      int mode_left, tick;
      mode = SINK_OPEN;
      mode_left = 0;
      tick = 0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_offs++;
         end
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         tick++;
         case (mode)
            SINK_OPEN:     rsp_bus.ready = 1'b1;
            SINK_COIN:     rsp_bus.ready = 1'($urandom_range(0, 1));
            SINK_SPARSE:   rsp_bus.ready = ($urandom_range(0, 3) == 0);
            SINK_PERIODIC: rsp_bus.ready = (tick % 5 != 0);
            default:       rsp_bus.ready = 1'b1;
         endcase
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int i, j, ops, target, start, sparse, phase_no;
      logic [63:0] t, gap;
      logic [CNT_W-1:0] value;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A search with a count of zero sees an empty table.
      drive_item(ACT_SEARCH, 0, 1'b0, 64'd0);

      // A table whose entries are all marked invalid never matches.
      for (i = 0; i < 4; i++) write_entry(i, 1'b0, 64'd100 * (i + 1));
      set_count(CNT_W'(4));
      drive_item(ACT_SEARCH, TABLE_SIZE - 1, 1'b1, 64'd200);

      // A sorted table with invalid holes; the last entry holds the largest
      // time that the week field can reach, one microsecond before week 65536.
      write_entry(0, 1'b1, 64'd1000);
      write_entry(1, 1'b0, 64'd2000);
      write_entry(2, 1'b0, 64'd2500);
      write_entry(3, 1'b1, 64'd3000);
      write_entry(4, 1'b1, 64'd4000);
      write_entry(5, 1'b0, 64'd5000);
      write_entry(6, 1'b1, 64'd6000);
      write_entry(7, 1'b1, KEY_MAX);
      filled = 8;
      set_count(CNT_W'(8));
      // Below the first valid time, equal to it (never probed, so the upper
      // bound comes back), exact hits, a key between entries, the last entry
      // and a key between the last two valid entries.
      drive_item(ACT_SEARCH, 5, 1'b0, 64'd999);
      drive_item(ACT_SEARCH, 6, 1'b1, 64'd1000);
      drive_item(ACT_SEARCH, 7, 1'b0, 64'd3000);
      drive_item(ACT_SEARCH, 8, 1'b1, 64'd3500);
      drive_item(ACT_SEARCH, 9, 1'b0, 64'd6000);
      drive_item(ACT_SEARCH, 10, 1'b1, KEY_MAX);
      drive_item(ACT_SEARCH, 11, 1'b0, US_PER_WEEK);

      // A single entry in use: both bounds sit on it.
      set_count(CNT_W'(1));
      drive_item(ACT_SEARCH, 12, 1'b1, 64'd1000);
      // Only invalid entries between the bounds: the upper bound is returned.
      set_count(CNT_W'(4));
      drive_item(ACT_SEARCH, 13, 1'b0, 64'd2000);
      // A key above the last valid entry in use is not found.
      set_count(CNT_W'(7));
      drive_item(ACT_SEARCH, 14, 1'b1, 64'd7000);

      // Random part. The early phases grow the table in sorted order up to its
      // full depth; each phase then sets a count, which may be zero or, once the table
      // is full, above its depth, and mixes searches with rewrites of written entries.
      phase_no = 0;
      while (sent_writes + sent_searches < ITEM_GOAL) begin
         if (filled < TABLE_SIZE) begin
            target = (filled < 32) ? 32 : (filled < 96) ? 96 : (filled < 256) ? 256 :
                     (filled < 512) ? 512 : TABLE_SIZE;
            start = (target == 32) ? 0 : filled;
            t = (start == 0) ? rand_key() / 2 : plan_time[start - 1];
            sparse = $urandom_range(0, 3) * 30;
            for (i = start; i < target; i++) begin
               case ($urandom_range(0, 19))
                  0: gap = 64'd0;
                  1, 2, 3, 4, 5, 6, 7, 8, 9: gap = 64'($urandom_range(1, 1000));
                  default: gap = 64'($urandom);
               endcase
               t = (t + gap > KEY_MAX) ? KEY_MAX : t + gap;
               write_entry(i, ($urandom_range(0, 99) >= sparse), t);
            end
            filled = target;
         end

         case (phase_no)
            4: value = CNT_W'(TABLE_SIZE);
            5: value = COUNT_TOP;
            7: value = '0;
            default: begin
               case ($urandom_range(0, 9))
                  0: value = CNT_W'($urandom_range(1, 4));
                  1: value = (filled == TABLE_SIZE) ?
                             CNT_W'($urandom_range(TABLE_SIZE + 1, 2047)) : CNT_W'(filled);
                  2: value = (filled == TABLE_SIZE) ? COUNT_TOP : CNT_W'(filled);
                  3, 4, 5: value = CNT_W'(filled);
                  default: value = CNT_W'($urandom_range(1, filled));
               endcase
            end
         endcase
         set_count(value);

         // In one phase the receiver goes quiet while the sender keeps offering.
         if (phase_no == 2) begin
            hold_off_pending = 1'b1;
            burst_left = 60;
         end

         ops = $urandom_range(40, 90);
         repeat (ops) begin
            if ($urandom_range(0, 3) == 0) begin
               j = $urandom_range(0, filled - 1);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: write_entry(j, ~plan_mark[j], plan_time[j]);
                  6, 7: write_entry(j, 1'b1, (j > 0) ? plan_time[j - 1] : plan_time[j]);
                  8: write_entry(j, 1'($urandom_range(0, 1)), plan_time[j]);
                  default: write_entry(j, 1'($urandom_range(0, 1)), rand_key());
               endcase
            end else begin
               drive_item(ACT_SEARCH, $urandom_range(0, TABLE_SIZE - 1),
                          1'($urandom_range(0, 1)), pick_key());
            end
         end
         phase_no++;
      end

      // Let the last responses come back, then give the block a little longer.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d table writes, %0d searches and %0d count settings",
               sent_writes, sent_searches, count_writes);
      $display("over %0d phases; the receiver held off %0d time(s) for %0d cycles.",
               phase_no, hold_offs, HOLD_OFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
